// ----- hdl/ttrr_pkg.sv -----
// Package for the round-robin thread table: request codes, thread states,
// scheduler modes and field widths. No dependencies.
package ttrr_pkg;

  localparam int DEFAULT_NUM_SLOTS = 8;
  localparam int SLOT_ID_W         = 4;
  localparam int SLICE_W           = 16;
  localparam int TICKS_W           = 17;
  localparam logic [SLICE_W-1:0] RESET_SLICE = 16'd9;

  typedef enum logic [2:0] {
    REQ_YIELD     = 3'd0,
    REQ_TICK      = 3'd1,
    REQ_ADD       = 3'd2,
    REQ_SET_STATE = 3'd3,
    REQ_GET_STATE = 3'd4,
    REQ_SET_SLICE = 3'd5,
    REQ_SET_MODE  = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_ENDED     = 2'd2,
    ST_SUSPENDED = 2'd3
  } thread_st_t;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_STARTED   = 2'd1,
    MODE_FIRST_RUN = 2'd2
  } mode_t;

endpackage

// ----- hdl/thread_table_round_robin.sv -----
// A started request passes the request and result registers to a one-cycle out_valid.
// Throughput: one request per cycle; the request register and the result register
// bracket a single pass over the slot table, so busy is high only during reset.
// Reset (synchronous, rst_n low): slot 0 running with a slice of 9, all other slots
// empty, current slot 0, mode first run, default slice 9. Results cannot be stalled.
// Top level of the thread table; depends on ttrr_pkg.
module thread_table_round_robin import ttrr_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_req_type,
  input  logic [SLOT_ID_W-1:0] in_slot_id,
  input  logic [1:0]           in_new_state,
  input  logic [TICKS_W-1:0]   in_slice_ticks,
  input  logic                 in_run_enable,
  output logic                 out_valid,
  output logic [SLOT_ID_W-1:0] out_result_slot,
  output logic                 out_ok,
  output logic [1:0]           out_slot_state,
  output logic [SLICE_W-1:0]   out_slice_out,
  output logic                 out_is_main,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SLICE_W-1:0]   cfg_data
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                 req_vld_r;
  req_t                 req_r;
  logic [SLOT_ID_W-1:0] slot_id_r;
  logic [1:0]           new_state_r;
  logic [TICKS_W-1:0]   ticks_r;
  logic                 run_en_r;

  logic [SLICE_W-1:0]   default_slice_r;
  logic [1:0]           flags_r  [NUM_SLOTS];
  logic [SLICE_W-1:0]   slices_r [NUM_SLOTS];
  logic [SW-1:0]        cur_r, cur_nxt;
  mode_t                mode_r, mode_nxt;

  logic                 out_valid_r;
  logic [SLOT_ID_W-1:0] res_slot_r, res_slot_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [1:0]           res_state_r, res_state_nxt;
  logic [SLICE_W-1:0]   res_slice_r, res_slice_nxt;
  logic                 res_main_r, res_main_nxt;

  logic [SW-1:0]        nxt_run;
  logic [SW-1:0]        free_idx;
  logic                 free_found;
  logic                 id_ok;
  logic [SW-1:0]        id_idx;
  logic [SW-1:0]        sel;
  logic                 wr_flag, wr_slice;
  logic [1:0]           wr_flag_val;
  logic [SLICE_W-1:0]   wr_slice_val;
  logic [SLICE_W-1:0]   new_slice;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start & ~busy;
    end
    if (start && !busy) begin
      req_r       <= req_t'(in_req_type);
      slot_id_r   <= in_slot_id;
      new_state_r <= in_new_state;
      ticks_r     <= in_slice_ticks;
      run_en_r    <= in_run_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_slice_r <= RESET_SLICE;
    end else if (cfg_valid && cfg_ready) begin
      default_slice_r <= cfg_data;
    end
  end

  // The next running slot strictly above the current one, else slot 0.
  always_comb begin
    nxt_run = '0;
    for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
      if (i > int'(cur_r) && flags_r[i] == ST_RUNNING) begin
        nxt_run = SW'(i);
      end
    end
  end

  // The lowest slot from 1 upward that is empty or ended.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
      if (flags_r[i] == ST_EMPTY || flags_r[i] == ST_ENDED) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign id_ok     = ({1'b0, slot_id_r} < (SLOT_ID_W + 1)'(NUM_SLOTS));
  assign id_idx    = slot_id_r[SW-1:0];
  assign new_slice = SLICE_W'(ticks_r - TICKS_W'(1));

  always_comb begin
    cur_nxt       = cur_r;
    mode_nxt      = mode_r;
    sel           = cur_r;
    wr_flag       = 1'b0;
    wr_slice      = 1'b0;
    wr_flag_val   = ST_RUNNING;
    wr_slice_val  = default_slice_r;
    res_slot_nxt  = SLOT_ID_W'(cur_r);
    res_ok_nxt    = 1'b0;
    res_state_nxt = '0;
    res_slice_nxt = '0;
    res_main_nxt  = 1'b0;
    case (req_r)
      REQ_YIELD, REQ_TICK: begin
        if (req_r == REQ_YIELD || mode_r == MODE_STARTED) begin
          sel          = nxt_run;
          cur_nxt      = nxt_run;
          res_slot_nxt = SLOT_ID_W'(nxt_run);
          res_ok_nxt   = 1'b1;
          res_main_nxt = (nxt_run == '0);
        end
        res_state_nxt = flags_r[sel];
        res_slice_nxt = slices_r[sel];
      end
      REQ_ADD: begin
        if (free_found) begin
          sel           = free_idx;
          wr_flag       = 1'b1;
          wr_slice      = 1'b1;
          mode_nxt      = (mode_r == MODE_STOPPED) ? MODE_STOPPED : MODE_STARTED;
          res_slot_nxt  = SLOT_ID_W'(free_idx);
          res_ok_nxt    = 1'b1;
          res_state_nxt = ST_RUNNING;
          res_slice_nxt = default_slice_r;
        end else begin
          mode_nxt     = (mode_r == MODE_STARTED) ? MODE_STARTED : MODE_STOPPED;
          res_slot_nxt = '0;
        end
      end
      REQ_SET_STATE, REQ_GET_STATE, REQ_SET_SLICE: begin
        sel          = id_idx;
        res_slot_nxt = slot_id_r;
        if (id_ok) begin
          wr_flag       = (req_r == REQ_SET_STATE);
          wr_slice      = (req_r == REQ_SET_SLICE);
          wr_flag_val   = new_state_r;
          wr_slice_val  = new_slice;
          res_state_nxt = wr_flag ? new_state_r : flags_r[sel];
          res_slice_nxt = wr_slice ? new_slice : slices_r[sel];
        end
      end
      REQ_SET_MODE: begin
        mode_nxt = run_en_r ? MODE_STARTED : MODE_STOPPED;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        flags_r[i]  <= (i == 0) ? ST_RUNNING : ST_EMPTY;
        slices_r[i] <= (i == 0) ? RESET_SLICE : '0;
      end
      cur_r  <= '0;
      mode_r <= MODE_FIRST_RUN;
    end else if (req_vld_r) begin
      if (wr_flag) begin
        flags_r[sel] <= wr_flag_val;
      end
      if (wr_slice) begin
        slices_r[sel] <= wr_slice_val;
      end
      cur_r  <= cur_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_vld_r;
    end
    if (req_vld_r) begin
      res_slot_r  <= res_slot_nxt;
      res_ok_r    <= res_ok_nxt;
      res_state_r <= res_state_nxt;
      res_slice_r <= res_slice_nxt;
      res_main_r  <= res_main_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_slot = res_slot_r;
  assign out_ok          = res_ok_r;
  assign out_slot_state  = res_state_r;
  assign out_slice_out   = res_slice_r;
  assign out_is_main     = res_main_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request produced no result two cycles later");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur_r) < NUM_SLOTS)
    else $error("current slot outside the table");

  a_main_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_main) |-> (out_ok && out_result_slot == '0))
    else $error("main flag without a switch to slot 0");

  a_set_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (req_vld_r && req_r == REQ_SET_MODE) |=>
      (mode_r == ($past(run_en_r) ? MODE_STARTED : MODE_STOPPED)))
    else $error("set mode did not update the scheduler mode");

endmodule
